/* design/jsu_pkg.sv */
// Shared types, constants and helpers for the JSON string unescaper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [20:0] SuppBase = 21'h010000;
  localparam logic [15:0] OneByteLimit = 16'h0080;
  localparam logic [15:0] TwoByteLimit = 16'h0800;
  localparam logic [4:0] SurrTop = 5'b11011;    // 0xD800..0xDFFF
  localparam logic [5:0] TrailTop = 6'b110111;  // 0xDC00..0xDFFF

  typedef enum logic [3:0] {
    ST_BYTE     = 4'd0,
    ST_END      = 4'd1,
    ST_NOQUOTE  = 4'd2,
    ST_CTRL     = 4'd3,
    ST_ESCAPE   = 4'd4,
    ST_HEX      = 4'd5,
    ST_LONE     = 4'd6,
    ST_NOU      = 4'd7,
    ST_BADTRAIL = 4'd8,
    ST_UNTERM   = 4'd9
  } status_e;

  typedef enum logic [3:0] {
    M_IDLE, M_BODY, M_ESC,
    M_HEX0, M_HEX1, M_HEX2, M_HEX3,
    M_LBS, M_LU,
    M_THEX0, M_THEX1, M_THEX2, M_THEX3
  } mode_e;

  // One queued job: up to four data bytes, then an optional status result.
  typedef struct packed {
    logic [2:0]       nbytes;
    logic             has_tail;
    status_e          tail;
    logic [3:0][7:0]  bytes;
  } job_t;

  // Hex digit value; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // Simple escape map; bit 8 set means not a simple escape.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] e;
    case (c)
      ChQuote:  e = {1'b0, ChQuote};
      ChBslash: e = {1'b0, ChBslash};
      ChSlash:  e = {1'b0, ChSlash};
      8'h62:    e = 9'h008;  // b
      8'h66:    e = 9'h00C;  // f
      8'h6E:    e = 9'h00A;  // n
      8'h72:    e = 9'h00D;  // r
      8'h74:    e = 9'h009;  // t
      default:  e = 9'h100;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* design/jsu_front.sv */
// Front end: takes source bytes, runs the escape/surrogate state machine and
// turns each byte into at most one job for the queue. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_end_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output jsu_pkg::job_t      q_job_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [11:0] acc_q, acc_d;    // first three hex digits
  logic [9:0]  lead_q, lead_d;
  logic        take;
  logic [4:0]  hv;
  logic [8:0]  esc;
  logic [15:0] cp;
  logic [20:0] cp21;
  job_t        job;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign hv         = hex_value(in_byte_i);
  assign esc        = simple_escape(in_byte_i);
  assign cp         = {acc_q, hv[3:0]};
  assign cp21       = {1'b0, lead_q, cp[9:0]} + SuppBase;

  // next state
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    lead_d = lead_q;
    case (mode_q)
      M_IDLE: begin
        if (in_byte_i == ChQuote) mode_d = M_BODY;
      end
      M_BODY: begin
        if (in_byte_i == ChQuote || in_byte_i < CtrlLimit) mode_d = M_IDLE;
        else if (in_byte_i == ChBslash) mode_d = M_ESC;
      end
      M_ESC: begin
        if (in_byte_i == ChU) mode_d = M_HEX0;
        else if (!esc[8]) mode_d = M_BODY;
        else mode_d = M_IDLE;
      end
      M_HEX0, M_HEX1, M_HEX2, M_THEX0, M_THEX1, M_THEX2: begin
        if (hv[4]) begin
          mode_d = M_IDLE;
        end else begin
          mode_d = mode_e'(mode_q + 4'd1);
          acc_d  = {acc_q[7:0], hv[3:0]};
        end
      end
      M_HEX3: begin
        if (hv[4]) mode_d = M_IDLE;
        else if (cp[15:11] != SurrTop) mode_d = M_BODY;
        else if (cp[15:10] != TrailTop) begin
          mode_d = M_LBS;
          lead_d = cp[9:0];
        end else mode_d = M_IDLE;
      end
      M_THEX3: begin
        if (hv[4] || cp[15:10] != TrailTop) mode_d = M_IDLE;
        else begin
          mode_d = M_BODY;
          lead_d = '0;
        end
      end
      M_LBS: mode_d = (in_byte_i == ChBslash) ? M_LU : M_IDLE;
      M_LU:  mode_d = (in_byte_i == ChU) ? M_THEX0 : M_IDLE;
      default: mode_d = M_IDLE;
    endcase
    if (mode_q == M_HEX3 || mode_q == M_THEX3) acc_d = '0;
    // buffer ran out with the string still open
    if (in_end_i) mode_d = M_IDLE;
    if (mode_d == M_IDLE) begin
      acc_d  = '0;
      lead_d = '0;
    end
  end

  // job for this byte
  always_comb begin
    job          = '0;
    job.tail     = ST_BYTE;
    case (mode_q)
      M_IDLE: begin
        if (in_byte_i != ChQuote) begin
          job.has_tail = 1'b1;
          job.tail     = ST_NOQUOTE;
        end
      end
      M_BODY: begin
        if (in_byte_i == ChQuote) begin
          job.has_tail = 1'b1;
          job.tail     = ST_END;
        end else if (in_byte_i < CtrlLimit) begin
          job.has_tail = 1'b1;
          job.tail     = ST_CTRL;
        end else if (in_byte_i != ChBslash) begin
          job.nbytes   = 3'd1;
          job.bytes[0] = in_byte_i;
        end
      end
      M_ESC: begin
        if (in_byte_i != ChU) begin
          if (!esc[8]) begin
            job.nbytes   = 3'd1;
            job.bytes[0] = esc[7:0];
          end else begin
            job.has_tail = 1'b1;
            job.tail     = ST_ESCAPE;
          end
        end
      end
      M_HEX0, M_HEX1, M_HEX2, M_THEX0, M_THEX1, M_THEX2: begin
        if (hv[4]) begin
          job.has_tail = 1'b1;
          job.tail     = ST_HEX;
        end
      end
      M_HEX3: begin
        if (hv[4]) begin
          job.has_tail = 1'b1;
          job.tail     = ST_HEX;
        end else if (cp < OneByteLimit) begin
          job.nbytes   = 3'd1;
          job.bytes[0] = cp[7:0];
        end else if (cp < TwoByteLimit) begin
          job.nbytes   = 3'd2;
          job.bytes[0] = {3'b110, cp[10:6]};
          job.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp[15:11] != SurrTop) begin
          job.nbytes   = 3'd3;
          job.bytes[0] = {4'b1110, cp[15:12]};
          job.bytes[1] = {2'b10, cp[11:6]};
          job.bytes[2] = {2'b10, cp[5:0]};
        end else if (cp[15:10] == TrailTop) begin
          job.has_tail = 1'b1;
          job.tail     = ST_LONE;
        end
      end
      M_THEX3: begin
        if (hv[4]) begin
          job.has_tail = 1'b1;
          job.tail     = ST_HEX;
        end else if (cp[15:10] != TrailTop) begin
          job.has_tail = 1'b1;
          job.tail     = ST_BADTRAIL;
        end else begin
          job.nbytes   = 3'd4;
          job.bytes[0] = {5'b11110, cp21[20:18]};
          job.bytes[1] = {2'b10, cp21[17:12]};
          job.bytes[2] = {2'b10, cp21[11:6]};
          job.bytes[3] = {2'b10, cp21[5:0]};
        end
      end
      M_LBS: begin
        if (in_byte_i != ChBslash) begin
          job.has_tail = 1'b1;
          job.tail     = ST_NOU;
        end
      end
      M_LU: begin
        if (in_byte_i != ChU) begin
          job.has_tail = 1'b1;
          job.tail     = ST_NOU;
        end
      end
      default: job.has_tail = 1'b0;
    endcase
    // an error or end already returned to idle, so at most one tail status
    if (in_end_i && !job.has_tail && !(mode_q == M_IDLE && in_byte_i != ChQuote)) begin
      job.has_tail = 1'b1;
      job.tail     = ST_UNTERM;
    end
  end

  assign q_job_o  = job;
  assign q_push_o = take && (job.nbytes != 3'd0 || job.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= '0;
      lead_q <= '0;
    end else if (take) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      lead_q <= lead_d;
    end
  end

endmodule

`default_nettype wire

/* design/jsu_queue.sv */
// Small job queue between front and back end, register based.
// Depends on jsu_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jsu_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output jsu_pkg::job_t      head_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* design/jsu_back.sv */
// Back end: holds one job and hands out its results one per cycle while the output is ready.
// Depends on jsu_pkg for the job type and status codes.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire jsu_pkg::job_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [3:0]         out_status_o,
  output logic               out_last_o
);
  import jsu_pkg::*;

  job_t       job_q;
  logic       have_q;
  logic [2:0] idx_q;
  logic [2:0] total;
  logic       fire, done, load;

  assign total        = job_q.nbytes + {2'b00, job_q.has_tail};
  assign out_valid_o  = have_q;
  assign out_last_o   = (idx_q == total - 3'd1);
  assign fire         = have_q && out_ready_i;
  assign done         = fire && out_last_o;
  assign load         = !have_q || done;
  assign q_pop_o      = load && !q_empty_i;

  always_comb begin
    if (idx_q < job_q.nbytes) begin
      out_byte_o   = job_q.bytes[idx_q[1:0]];
      out_status_o = ST_BYTE;
    end else begin
      out_byte_o   = '0;
      out_status_o = job_q.tail;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      have_q <= !q_empty_i;
      idx_q  <= '0;
    end else if (fire) begin
      idx_q  <= idx_q + 3'd1;
    end
  end

endmodule

`default_nettype wire

/* design/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper: front decoder, job queue, back emitter.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-------------------------------------
//  source   | in  | s_axis_tvalid/tready  | tdata[7:0] in_byte, tlast buffer_end
//  result   | out | m_axis_tvalid/tready  | tdata[7:0] out_byte, [11:8] status,
//           |     |                       | tlast last
//
// One source item is taken per cycle while the job queue has room; the front
// decoder finishes each item in that cycle and queues at most one job.
// The back end gives one result per cycle while m_axis_tready is high; an item has
// up to five results (four bytes and a status for a surrogate pair ending the buffer); the queue
// (QueueDepth jobs) absorbs these bursts and output stalls.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // buffer_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_byte, [11:8] status, zero pad
  output logic             m_axis_tlast_o    // last result of the source item
);
  import jsu_pkg::*;

  job_t       push_job, head_job;
  logic       push, full, pop, empty;
  logic [7:0] out_byte;
  logic [3:0] out_status;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tlast_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_job_o    (push_job)
  );

  // decouples decoding from emission so each side stalls on its own
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty),
    .q_head_i     (head_job),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'h0, out_status, out_byte};

endmodule

`default_nettype wire
